// ===== src/nsfp_pkg.sv =====
// Shared constants, types and helpers for the NMEA sentence field parser.
package nsfp_pkg;

    // Default sizing
    localparam int FIELD_SLOTS_DEF     = 16;
    localparam int FRACTION_DIGITS_DEF = 5;
    localparam int INTEGER_DIGITS_DEF  = 6;

    // Output field widths
    localparam int INT_PART_W  = 20;
    localparam int FRAC_PART_W = 17;
    localparam int FIELD_IDX_W = 4;

    // Field positions that carry the fix status
    localparam int FLD_RMC_STATUS = 2;
    localparam int FLD_GGA_QUAL   = 6;

    // Characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Sentence kinds
    localparam logic [1:0] SK_OTHER = 2'd0;
    localparam logic [1:0] SK_GGA   = 2'd1;
    localparam logic [1:0] SK_RMC   = 2'd2;

    // Record kinds
    localparam logic REC_FIELD = 1'b0;
    localparam logic REC_END   = 1'b1;

    // Control from the sentence tracker to the field accumulator
    typedef struct packed {
        logic       step;   // byte consumed this cycle
        logic       clear;  // start a new field
        logic       take;   // add byte to current field
        logic [7:0] chr;
    } t_fld_ctl;

    // Current field value, already scaled and sized for the result
    typedef struct packed {
        logic [INT_PART_W-1:0]  int_part;
        logic [FRAC_PART_W-1:0] frac_part;
        logic                   is_negative;
        logic [7:0]             first_char;
        logic                   field_empty;
        logic                   int_zero;
    } t_fld_val;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex_dig;

    // ASCII hex digit decode
    function automatic t_hex_dig hex_decode(input logic [7:0] c);
        t_hex_dig h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.val = 4'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            h.val = 4'(c - CH_UP_A + 8'd10);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            h.val = 4'(c - CH_LO_A + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Powers of ten for fraction scaling
    function automatic logic [23:0] pow10(input logic [2:0] n);
        logic [23:0] p;
        case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

// ===== src/nsfp_in_reg.sv =====
// Input holding register for received bytes.
module nsfp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    // Slot frees when empty or when the held byte is consumed
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ===== src/nsfp_field_acc.sv =====
// Decimal field accumulator: integer, fraction, sign and first character.
module nsfp_field_acc #(
    parameter int FRACTION_DIGITS = nsfp_pkg::FRACTION_DIGITS_DEF,
    parameter int INTEGER_DIGITS  = nsfp_pkg::INTEGER_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nsfp_pkg::t_fld_ctl i_ctl,
    output nsfp_pkg::t_fld_val o_val,
    output logic               o_overflow
);
    import nsfp_pkg::*;

    localparam int INT_W = $clog2(10**INTEGER_DIGITS);
    localparam int FRAC_W = $clog2(10**FRACTION_DIGITS);
    localparam int FDC_W = $clog2(FRACTION_DIGITS + 1);
    localparam logic [INT_W+3:0] INT_LIM = (INT_W+4)'(10**INTEGER_DIGITS - 1);

    logic [INT_W-1:0]  r_int;
    logic [FRAC_W-1:0] r_frac;
    logic [FDC_W-1:0]  r_fdc;
    logic              r_seen_point;
    logic              r_neg;
    logic [7:0]        r_first;
    logic              r_has_char;

    logic              is_digit;
    logic [3:0]        digit;
    logic [INT_W+3:0]  int_mul;
    logic [FRAC_W+3:0] frac_mul;
    logic              frac_room;
    logic [FRAC_W+23:0] frac_scaled;

    // Next-digit arithmetic: times ten plus digit
    assign is_digit  = (i_ctl.chr >= CH_ZERO) && (i_ctl.chr <= CH_NINE);
    assign digit     = 4'(i_ctl.chr - CH_ZERO);
    assign int_mul   = ((INT_W+4)'(r_int) << 3) + ((INT_W+4)'(r_int) << 1)
                       + (INT_W+4)'(digit);
    assign frac_mul  = ((FRAC_W+4)'(r_frac) << 3) + ((FRAC_W+4)'(r_frac) << 1)
                       + (FRAC_W+4)'(digit);
    assign frac_room = r_fdc < FDC_W'(FRACTION_DIGITS);

    // Saturation of the integer part; qualified by the caller
    assign o_overflow = is_digit && !r_seen_point && (int_mul > INT_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int        <= '0;
            r_frac       <= '0;
            r_fdc        <= '0;
            r_seen_point <= 1'b0;
            r_neg        <= 1'b0;
            r_first      <= '0;
            r_has_char   <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.clear) begin
                r_int        <= '0;
                r_frac       <= '0;
                r_fdc        <= '0;
                r_seen_point <= 1'b0;
                r_neg        <= 1'b0;
                r_first      <= '0;
                r_has_char   <= 1'b0;
            end else if (i_ctl.take) begin
                if (!r_has_char) begin
                    r_first <= i_ctl.chr;
                    if (i_ctl.chr == CH_MINUS) begin
                        r_neg <= 1'b1;
                    end
                end
                r_has_char <= 1'b1;
                if (is_digit) begin
                    if (!r_seen_point) begin
                        r_int <= (int_mul > INT_LIM) ? INT_W'(INT_LIM) : INT_W'(int_mul);
                    end else if (frac_room) begin
                        r_frac <= FRAC_W'(frac_mul);
                        r_fdc  <= r_fdc + 1'b1;
                    end
                end else if (i_ctl.chr == CH_POINT) begin
                    r_seen_point <= 1'b1;
                end
            end
        end
    end

    // Scale fraction to the full digit count
    assign frac_scaled = (FRAC_W+24)'(r_frac)
                         * (FRAC_W+24)'(pow10(3'(FRACTION_DIGITS - int'(r_fdc))));

    assign o_val.int_part    = INT_PART_W'(r_int);
    assign o_val.frac_part   = FRAC_PART_W'(frac_scaled);
    assign o_val.is_negative = r_neg;
    assign o_val.first_char  = r_has_char ? r_first : 8'd0;
    assign o_val.field_empty = !r_has_char;
    assign o_val.int_zero    = (r_int == '0);
endmodule

// ===== src/nmea_sentence_field_parser.sv =====
// NMEA sentence field parser top level: sentence tracking, checksum, result register.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+-----------------------------------------
//  in      | i_in_valid | o_in_ready  | i_in_byte
//  out     | o_out_valid| i_out_ready | o_record_kind .. o_format_error
//
// One byte per cycle while the output is not stalled: a byte waits in the input
// register, is decoded and folded into the sentence and field state, and its record
// (if any) lands in the output register on the same edge. Each record thus passes
// the input register and then the output register, and holds there until it transfers.
// Reset is synchronous, active low; no clearing pass.
// A stalled output holds the next record-producing byte in the input register;
// bytes that make no record keep flowing.
module nmea_sentence_field_parser #(
    parameter int FIELD_SLOTS     = nsfp_pkg::FIELD_SLOTS_DEF,
    parameter int FRACTION_DIGITS = nsfp_pkg::FRACTION_DIGITS_DEF,
    parameter int INTEGER_DIGITS  = nsfp_pkg::INTEGER_DIGITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_in_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_record_kind,
    output logic [1:0]                       o_sentence_kind,
    output logic [nsfp_pkg::FIELD_IDX_W-1:0] o_field_index,
    output logic [nsfp_pkg::INT_PART_W-1:0]  o_int_part,
    output logic [nsfp_pkg::FRAC_PART_W-1:0] o_frac_part,
    output logic                             o_is_negative,
    output logic [7:0]                       o_first_char,
    output logic                             o_field_empty,
    output logic                             o_checksum_ok,
    output logic                             o_fix_lost,
    output logic                             o_format_error
);
    import nsfp_pkg::*;

    localparam int CNT_W = $clog2(FIELD_SLOTS);

    // Input stage
    logic       in_valid;
    logic [7:0] c;
    logic       advance;

    // Sentence state
    logic             r_in_sent, n_in_sent;
    logic             r_after, n_after;
    logic [1:0]       r_kind, n_kind;
    logic [1:0]       r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_rx, n_rx;
    logic [1:0]       r_hex_cnt, n_hex_cnt;
    logic             r_rmc_void, n_rmc_void;
    logic             r_gga_nofix, n_gga_nofix;
    logic             r_err, n_err;

    // Field accumulator link
    t_fld_ctl fctl;
    t_fld_val fval;
    logic     fld_ovf;
    logic     fld_clear;
    logic     fld_take;
    t_hex_dig hx;

    // Result being formed
    logic                   has_res;
    logic                   emit_fld;
    logic                   res_kind;
    logic [1:0]             res_skind;
    logic                   res_ck;
    logic                   res_fl;
    logic                   res_fe;

    // Output register
    logic                   r_out_valid;
    logic                   r_rec_kind;
    logic [1:0]             r_skind;
    logic [FIELD_IDX_W-1:0] r_fidx;
    logic [INT_PART_W-1:0]  r_int;
    logic [FRAC_PART_W-1:0] r_frac;
    logic                   r_neg;
    logic [7:0]             r_first;
    logic                   r_empty;
    logic                   r_ck;
    logic                   r_fl;
    logic                   r_fe;

    nsfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_byte    (i_in_byte),
        .o_ready   (o_in_ready),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (c)
    );

    nsfp_field_acc #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .INTEGER_DIGITS  (INTEGER_DIGITS)
    ) u_field_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (fctl),
        .o_val      (fval),
        .o_overflow (fld_ovf)
    );

    assign hx = hex_decode(c);

    // Byte decode and next sentence state
    always_comb begin
        n_in_sent   = r_in_sent;
        n_after     = r_after;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_xor       = r_xor;
        n_rx        = r_rx;
        n_hex_cnt   = r_hex_cnt;
        n_rmc_void  = r_rmc_void;
        n_gga_nofix = r_gga_nofix;
        n_err       = r_err;
        fld_clear   = 1'b0;
        fld_take    = 1'b0;
        has_res     = 1'b0;
        emit_fld    = 1'b0;
        res_kind    = REC_FIELD;
        res_ck      = 1'b0;
        res_fl      = 1'b0;
        res_fe      = 1'b0;

        if (c == CH_DOLLAR) begin
            // Sentence start, also restarts an open sentence
            n_in_sent  = 1'b1;
            n_after    = 1'b0;
            n_kind     = SK_OTHER;
            n_pos      = 2'd0;
            n_cnt      = '0;
            n_xor      = 8'd0;
            n_rx       = 8'd0;
            n_hex_cnt  = 2'd0;
            n_err      = 1'b0;
            fld_clear  = 1'b1;
        end else if (r_in_sent && c != CH_CR) begin
            if (c == CH_LF) begin
                // End of sentence record
                has_res   = 1'b1;
                res_kind  = REC_END;
                res_ck    = r_after && (r_hex_cnt == 2'd2) && (r_rx == r_xor);
                res_fl    = r_rmc_void || r_gga_nofix;
                res_fe    = !r_after || r_err || (r_hex_cnt != 2'd2);
                n_in_sent = 1'b0;
                n_after   = 1'b0;
            end else if (r_after) begin
                // Checksum digits
                if (!hx.ok || r_hex_cnt == 2'd2) begin
                    n_err = 1'b1;
                end else begin
                    n_rx      = {r_rx[3:0], hx.val};
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end
            end else begin
                // Character position; kind comes from the third character
                if (r_pos != 2'd3) begin
                    n_pos = r_pos + 2'd1;
                end
                if (r_pos == 2'd2) begin
                    n_kind = (c == CH_G) ? SK_GGA : (c == CH_R) ? SK_RMC : SK_OTHER;
                end
                if (c == CH_STAR) begin
                    emit_fld   = 1'b1;
                    fld_clear  = 1'b1;
                    n_after    = 1'b1;
                    n_rx       = 8'd0;
                    n_hex_cnt  = 2'd0;
                end else begin
                    n_xor = r_xor ^ c;
                    if (c == CH_COMMA) begin
                        emit_fld   = 1'b1;
                        fld_clear  = 1'b1;
                        if (r_cnt < CNT_W'(FIELD_SLOTS - 1)) begin
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else begin
                        fld_take = 1'b1;
                        if (fld_ovf) begin
                            n_err = 1'b1;
                        end
                    end
                end
            end
        end

        // Field record and fix status tracking
        if (emit_fld) begin
            has_res = 1'b1;
            if (n_kind == SK_RMC && r_cnt == CNT_W'(FLD_RMC_STATUS)) begin
                n_rmc_void = !fval.field_empty && (fval.first_char == CH_V);
            end
            if (n_kind == SK_GGA && r_cnt == CNT_W'(FLD_GGA_QUAL)) begin
                n_gga_nofix = fval.int_zero;
            end
        end
        res_skind = n_kind;
    end

    // Consume the held byte unless its record cannot be placed
    assign advance = in_valid && (!has_res || !r_out_valid || i_out_ready);

    // Accumulator control: step, clear, take, character
    assign fctl = {advance, fld_clear, fld_take, c};

    // Sentence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sent   <= 1'b0;
            r_after     <= 1'b0;
            r_kind      <= SK_OTHER;
            r_pos       <= 2'd0;
            r_cnt       <= '0;
            r_xor       <= 8'd0;
            r_rx        <= 8'd0;
            r_hex_cnt   <= 2'd0;
            r_rmc_void  <= 1'b1;
            r_gga_nofix <= 1'b1;
            r_err       <= 1'b0;
        end else if (advance) begin
            r_in_sent   <= n_in_sent;
            r_after     <= n_after;
            r_kind      <= n_kind;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_xor       <= n_xor;
            r_rx        <= n_rx;
            r_hex_cnt   <= n_hex_cnt;
            r_rmc_void  <= n_rmc_void;
            r_gga_nofix <= n_gga_nofix;
            r_err       <= n_err;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (advance && has_res) begin
            r_rec_kind <= res_kind;
            r_skind    <= res_skind;
            r_fidx     <= FIELD_IDX_W'(r_cnt);
            r_ck       <= res_ck;
            r_fl       <= res_fl;
            r_fe       <= res_fe;
            if (res_kind == REC_END) begin
                r_int   <= '0;
                r_frac  <= '0;
                r_neg   <= 1'b0;
                r_first <= 8'd0;
                r_empty <= 1'b0;
            end else begin
                r_int   <= fval.int_part;
                r_frac  <= fval.frac_part;
                r_neg   <= fval.is_negative;
                r_first <= fval.first_char;
                r_empty <= fval.field_empty;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_record_kind   = r_rec_kind;
    assign o_sentence_kind = r_skind;
    assign o_field_index   = r_fidx;
    assign o_int_part      = r_int;
    assign o_frac_part     = r_frac;
    assign o_is_negative   = r_neg;
    assign o_first_char    = r_first;
    assign o_field_empty   = r_empty;
    assign o_checksum_ok   = r_ck;
    assign o_fix_lost      = r_fl;
    assign o_format_error  = r_fe;
endmodule

// ===== tb/nmea_record_checker.sv =====
// Record checker: predicts parser records from input transfers and compares output transfers.
module nmea_record_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [7:0]                       i_in_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_record_kind,
    input  logic [1:0]                       i_sentence_kind,
    input  logic [nsfp_pkg::FIELD_IDX_W-1:0] i_field_index,
    input  logic [nsfp_pkg::INT_PART_W-1:0]  i_int_part,
    input  logic [nsfp_pkg::FRAC_PART_W-1:0] i_frac_part,
    input  logic                             i_is_negative,
    input  logic [7:0]                       i_first_char,
    input  logic                             i_field_empty,
    input  logic                             i_checksum_ok,
    input  logic                             i_fix_lost,
    input  logic                             i_format_error,
    output int                               o_fail_count,
    output int                               o_pending
);
    import nsfp_pkg::*;

    typedef struct packed {
        logic                   record_kind;
        logic [1:0]             sentence_kind;
        logic [FIELD_IDX_W-1:0] field_index;
        logic [INT_PART_W-1:0]  int_part;
        logic [FRAC_PART_W-1:0] frac_part;
        logic                   is_negative;
        logic [7:0]             first_char;
        logic                   field_empty;
        logic                   checksum_ok;
        logic                   fix_lost;
        logic                   format_error;
    } t_nmea_record;

    t_nmea_record expected_records[$];
    int           fail_count = 0;

    // Sentence state
    logic                   in_sentence;
    logic                   past_star;
    logic [1:0]             sentence_kind;
    logic [7:0]             char_pos;
    logic [FIELD_IDX_W-1:0] field_idx;
    logic [7:0]             running_xor;
    logic [7:0]             sent_sum;
    int unsigned            hex_count;
    logic                   rmc_void;
    logic                   gga_nofix;
    logic                   bad_format;

    // Current field state
    int unsigned            int_value;
    int unsigned            frac_value;
    int unsigned            frac_count;
    logic                   point_seen;
    logic                   minus_seen;
    logic [7:0]             lead_char;
    int unsigned            char_count;

    function automatic int unsigned power_of_ten(input int unsigned n);
        int unsigned p;
        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    // Returns -1 for anything that is not an ASCII hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
        return -1;
    endfunction

    function void clear_field();
        int_value  = 0;
        frac_value = 0;
        frac_count = 0;
        point_seen = 1'b0;
        minus_seen = 1'b0;
        lead_char  = 8'h00;
        char_count = 0;
    endfunction

    function void start_sentence();
        in_sentence   = 1'b1;
        past_star     = 1'b0;
        sentence_kind = SK_OTHER;
        char_pos      = 8'd0;
        field_idx     = '0;
        running_xor   = 8'h00;
        sent_sum      = 8'h00;
        hex_count     = 0;
        bad_format    = 1'b0;
        clear_field();
    endfunction

    function void reset_parser();
        start_sentence();
        in_sentence = 1'b0;
        rmc_void    = 1'b1;
        gga_nofix   = 1'b1;
        expected_records.delete();
    endfunction

    function void push_record(input logic rk, input int unsigned ip, input int unsigned fp,
                              input logic ng, input logic [7:0] fc, input logic emp,
                              input logic ck, input logic fl, input logic fe);
        t_nmea_record r;
        r.record_kind   = rk;
        r.sentence_kind = sentence_kind;
        r.field_index   = field_idx;
        r.int_part      = INT_PART_W'(ip);
        r.frac_part     = FRAC_PART_W'(fp);
        r.is_negative   = ng;
        r.first_char    = fc;
        r.field_empty   = emp;
        r.checksum_ok   = ck;
        r.fix_lost      = fl;
        r.format_error  = fe;
        expected_records.push_back(r);
    endfunction

    // Field record at a separator, then fix status tracking
    function void close_field();
        push_record(REC_FIELD, int_value,
                    frac_value * power_of_ten(FRACTION_DIGITS_DEF - frac_count),
                    minus_seen, (char_count != 0) ? lead_char : 8'h00,
                    char_count == 0, 1'b0, 1'b0, 1'b0);
        if (sentence_kind == SK_RMC && field_idx == FLD_RMC_STATUS) begin
            rmc_void = (char_count != 0 && lead_char == CH_V);
        end
        if (sentence_kind == SK_GGA && field_idx == FLD_GGA_QUAL) begin
            gga_nofix = (int_value == 0);
        end
        clear_field();
    endfunction

    function void take_char(input logic [7:0] c);
        int unsigned digit;
        int unsigned widened;
        if (char_count == 0) begin
            lead_char = c;
            if (c == CH_MINUS) minus_seen = 1'b1;
        end
        if (char_count < 15) char_count++;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            digit = int'(c - CH_ZERO);
            if (!point_seen) begin
                // integer part saturates and flags the sentence
                widened = int_value * 10 + digit;
                if (widened > power_of_ten(INTEGER_DIGITS_DEF) - 1) begin
                    widened    = power_of_ten(INTEGER_DIGITS_DEF) - 1;
                    bad_format = 1'b1;
                end
                int_value = widened;
            end else if (frac_count < FRACTION_DIGITS_DEF) begin
                frac_value = frac_value * 10 + digit;
                frac_count++;
            end
        end else if (c == CH_POINT) begin
            point_seen = 1'b1;
        end
    endfunction

    function void parse_byte(input logic [7:0] c);
        int   h;
        logic ck;
        logic fe;
        if (c == CH_DOLLAR) begin
            start_sentence();
            return;
        end
        if (!in_sentence || c == CH_CR) return;

        // End of sentence
        if (c == CH_LF) begin
            if (past_star) begin
                ck = (hex_count == 2 && sent_sum == running_xor);
                fe = bad_format || hex_count != 2;
            end else begin
                ck = 1'b0;
                fe = 1'b1;
            end
            push_record(REC_END, 0, 0, 1'b0, 8'h00, 1'b0, ck, rmc_void | gga_nofix, fe);
            in_sentence = 1'b0;
            past_star   = 1'b0;
            return;
        end

        // Checksum digits
        if (past_star) begin
            h = hex_nibble(c);
            if (h < 0 || hex_count >= 2) begin
                bad_format = 1'b1;
            end else begin
                sent_sum = {sent_sum[3:0], h[3:0]};
                hex_count++;
            end
            return;
        end

        if (char_pos < 8'd255) char_pos++;
        if (char_pos == 8'd3) begin
            sentence_kind = (c == CH_G) ? SK_GGA : (c == CH_R) ? SK_RMC : SK_OTHER;
        end

        if (c == CH_STAR) begin
            close_field();
            past_star = 1'b1;
            sent_sum  = 8'h00;
            hex_count = 0;
            return;
        end

        running_xor ^= c;

        if (c == CH_COMMA) begin
            close_field();
            if (field_idx < FIELD_SLOTS_DEF - 1) field_idx++;
            else bad_format = 1'b1;
            return;
        end

        take_char(c);
    endfunction

    function void check_value(input string name, input longint unsigned want_v,
                              input longint unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    function void compare_record();
        t_nmea_record want;
        if (expected_records.size() == 0) begin
            $display("%0t: record with nothing expected, expected none, actual kind %0d index %0d",
                     $time, i_record_kind, i_field_index);
            fail_count++;
            return;
        end
        want = expected_records.pop_front();
        check_value("record_kind",   want.record_kind,   i_record_kind);
        check_value("sentence_kind", want.sentence_kind, i_sentence_kind);
        check_value("field_index",   want.field_index,   i_field_index);
        check_value("int_part",      want.int_part,      i_int_part);
        check_value("frac_part",     want.frac_part,     i_frac_part);
        check_value("is_negative",   want.is_negative,   i_is_negative);
        check_value("first_char",    want.first_char,    i_first_char);
        check_value("field_empty",   want.field_empty,   i_field_empty);
        check_value("checksum_ok",   want.checksum_ok,   i_checksum_ok);
        check_value("fix_lost",      want.fix_lost,      i_fix_lost);
        check_value("format_error",  want.format_error,  i_format_error);
    endfunction

    // Input transfers feed the prediction, output transfers are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
        end else begin
            if (i_in_valid && i_in_ready) parse_byte(i_in_byte);
            if (i_out_valid && i_out_ready) compare_record();
        end
        o_pending    = expected_records.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== tb/nmea_sentence_field_parser_tb.sv =====
// Testbench top: drives an NMEA byte stream into the parser and gives the verdict.
module nmea_sentence_field_parser_tb;
    import nsfp_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int BYTES_PER_PHASE = 375;

    typedef logic [7:0] t_byte_q[$];

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic [7:0]             i_in_byte   = 8'h00;
    logic                   i_out_ready = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic                   o_record_kind;
    logic [1:0]             o_sentence_kind;
    logic [FIELD_IDX_W-1:0] o_field_index;
    logic [INT_PART_W-1:0]  o_int_part;
    logic [FRAC_PART_W-1:0] o_frac_part;
    logic                   o_is_negative;
    logic [7:0]             o_first_char;
    logic                   o_field_empty;
    logic                   o_checksum_ok;
    logic                   o_fix_lost;
    logic                   o_format_error;

    int      send_idle_pct = 36;
    int      recv_idle_pct = 86;
    bit      hold_pending  = 1'b0;
    int      cycle_count   = 0;
    int      sent_bytes    = 0;
    int      fail_count;
    int      pending_count;
    t_byte_q line_bytes;

    nmea_sentence_field_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_record_kind   (o_record_kind),
        .o_sentence_kind (o_sentence_kind),
        .o_field_index   (o_field_index),
        .o_int_part      (o_int_part),
        .o_frac_part     (o_frac_part),
        .o_is_negative   (o_is_negative),
        .o_first_char    (o_first_char),
        .o_field_empty   (o_field_empty),
        .o_checksum_ok   (o_checksum_ok),
        .o_fix_lost      (o_fix_lost),
        .o_format_error  (o_format_error)
    );

    nmea_record_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_record_kind   (o_record_kind),
        .i_sentence_kind (o_sentence_kind),
        .i_field_index   (o_field_index),
        .i_int_part      (o_int_part),
        .i_frac_part     (o_frac_part),
        .i_is_negative   (o_is_negative),
        .i_first_char    (o_first_char),
        .i_field_empty   (o_field_empty),
        .i_checksum_ok   (o_checksum_ok),
        .i_fix_lost      (o_fix_lost),
        .i_format_error  (o_format_error),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nmea_sentence_field_parser_tb failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One byte transfer; valid stays up between back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CH_LF);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'(CH_ZERO + n);
        return 8'((lower ? CH_LO_A : CH_UP_A) + n - 4'd10);
    endfunction

    // Well-formed sentence with its correct checksum
    task automatic send_framed(input string body, input bit lower);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < body.len(); i++) sum ^= body[i];
        send_byte(CH_DOLLAR);
        send_text(body);
        send_byte(CH_STAR);
        send_byte(hex_char(sum[7:4], lower));
        send_byte(hex_char(sum[3:0], lower));
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // Any byte that does not frame or split a sentence
    function automatic logic [7:0] plain_noise_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == CH_DOLLAR || c == CH_COMMA || c == CH_STAR || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function void add_number();
        int n;
        if ($urandom_range(3) == 0) line_bytes.push_back(CH_MINUS);
        n = ($urandom_range(7) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 5);
        repeat (n) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(2) != 0) begin
            line_bytes.push_back(CH_POINT);
            n = $urandom_range(0, 7);
            repeat (n) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(15) == 0) line_bytes.push_back(CH_POINT);
        end
    endfunction

    function void add_random_field(input int idx, input logic [7:0] kind_ch);
        int sel;
        int n;
        sel = $urandom_range(99);
        // status fields get realistic values most of the time
        if (kind_ch == CH_R && idx == FLD_RMC_STATUS && sel < 70) begin
            if (sel < 60) line_bytes.push_back($urandom_range(1) ? CH_V : CH_UP_A);
            return;
        end
        if (kind_ch == CH_G && idx == FLD_GGA_QUAL && sel < 70) begin
            if (sel < 60) line_bytes.push_back(8'(CH_ZERO + $urandom_range(2)));
            return;
        end
        if (sel < 15) return;
        if (sel < 70) begin
            add_number();
            return;
        end
        n = $urandom_range(1, 3);
        if (sel < 85) repeat (n) line_bytes.push_back(8'(CH_UP_A + $urandom_range(25)));
        else repeat (n) line_bytes.push_back(plain_noise_byte());
    endfunction

    // Mostly well-formed sentences with random content; some noise and broken tails
    task automatic send_random_sentence();
        int         sel;
        int         nfields;
        logic [7:0] kind_ch;
        logic [7:0] sum;
        bit         lower;
        sel = $urandom_range(99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
            return;
        end

        line_bytes.delete();
        repeat (2) line_bytes.push_back(8'(CH_UP_A + $urandom_range(25)));
        case ($urandom_range(3))
            0:       kind_ch = CH_G;
            1:       kind_ch = CH_R;
            default: kind_ch = 8'(CH_UP_A + $urandom_range(25));
        endcase
        line_bytes.push_back(kind_ch);
        repeat ($urandom_range(0, 2)) line_bytes.push_back(8'(CH_UP_A + $urandom_range(25)));
        nfields = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 9);
        for (int f = 1; f <= nfields; f++) begin
            line_bytes.push_back(CH_COMMA);
            add_random_field(f, kind_ch);
        end
        if ($urandom_range(9) == 0) line_bytes.insert($urandom_range(line_bytes.size()), CH_CR);

        sum = 8'h00;
        foreach (line_bytes[i]) if (line_bytes[i] != CH_CR) sum ^= line_bytes[i];
        line_bytes.push_front(CH_DOLLAR);

        // Tail: good, wrong, short, long or bad checksum, missing star, or cut off
        sel   = $urandom_range(99);
        lower = $urandom_range(1);
        if (sel < 97) begin
            if (sel < 94) begin
                line_bytes.push_back(CH_STAR);
                if (sel >= 75 && sel < 83) sum ^= 8'($urandom_range(1, 255));
                if (sel < 83) begin
                    line_bytes.push_back(hex_char(sum[7:4], lower));
                    line_bytes.push_back(hex_char(sum[3:0], lower));
                end else if (sel < 87) begin
                    line_bytes.push_back(hex_char(sum[3:0], lower));
                end else if (sel < 91) begin
                    line_bytes.push_back(hex_char(sum[7:4], lower));
                    line_bytes.push_back(hex_char(sum[3:0], lower));
                    line_bytes.push_back(hex_char(4'($urandom_range(15)), lower));
                end else begin
                    line_bytes.push_back(plain_noise_byte());
                    line_bytes.push_back(hex_char(sum[3:0], lower));
                end
            end
            if ($urandom_range(3) != 0) line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
        end
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
    endtask

    // Stimulus and verdict
    initial begin
        int  target;
        bit  hold_done;
        hold_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bytes outside sentences, value extremes, fix status, broken tails
        send_byte(8'h00);
        send_byte(8'hFF);
        send_line("x,*1");
        send_framed("GPGGA,-12.5,999999,1234567,0.123456,,-,7.,1.2.3", 1'b0);
        send_framed("GPRMC,1,V,ab", 1'b1);
        send_framed("GPRMC,,A,x", 1'b0);
        send_framed("GPGGA,1,2,3,4,5,1,.99999", 1'b0);
        send_text("$GPGG");
        send_line("$GPRMC,5,V*00");
        send_line("$AB,1");
        send_line("$G");
        send_line("$GPX,1*1G");
        send_line("$GPX,1*123");
        send_line("$GPX,1*1");
        send_framed("GPZDA,,,,,,,,,,,,,,,,,,9", 1'b1);
        send_text("$GP");
        send_byte(CH_CR);
        send_text("R,");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_line("*7f");

        // Random phases: sender/receiver idle 36/86, then 86/36, then none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 86 : 0;
            recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 36 : 0;
            target = sent_bytes + BYTES_PER_PHASE;
            while (sent_bytes < target) begin
                if (phase == 2 && !hold_done && sent_bytes > target - 300) begin
                    hold_pending = 1'b1;
                    hold_done    = 1'b1;
                end
                send_random_sentence();
            end
        end

        // Drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("nmea_sentence_field_parser_tb passed");
        end else begin
            $display("nmea_sentence_field_parser_tb failed");
        end
        $finish;
    end

endmodule

// ===== nmea_sentence_field_parser.f =====
src/nsfp_pkg.sv
src/nsfp_in_reg.sv
src/nsfp_field_acc.sv
src/nmea_sentence_field_parser.sv
tb/nmea_record_checker.sv
tb/nmea_sentence_field_parser_tb.sv
